// ===== rtl/acars_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package acars_pkg;

  // longest frame text before the frame is dropped
  localparam int unsigned MAX_TEXT = 243;

  // crc-16 ccitt polynomial
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // sync and framing bytes
  localparam logic [7:0] BYTE_PRE   = 8'hFF;
  localparam logic [7:0] BYTE_BS1   = 8'hAB;
  localparam logic [7:0] BYTE_BS2   = 8'h2A;
  localparam logic [7:0] BYTE_SYN   = 8'h16;
  localparam logic [7:0] BYTE_SOH   = 8'h01;
  localparam logic [6:0] CHR_ETX    = 7'h03;
  localparam logic [6:0] CHR_ETB    = 7'h17;
  localparam logic [6:0] CHR_CR     = 7'h0D;
  localparam logic [6:0] CHR_LF     = 7'h0A;
  localparam logic [6:0] CHR_NAK    = 7'h15;
  localparam logic [6:0] CHR_SPACE  = 7'h20;
  localparam logic [7:0] CHR_SUBST  = 8'hA4;

  // bit counts reported to the demodulator
  localparam logic [3:0] NB_BYTE = 4'd8;
  localparam logic [3:0] NB_PRE  = 4'd6;
  localparam logic [3:0] NB_DONE = 4'd0;

  localparam logic [2:0] MSE_RESET = 3'd2;

  typedef enum logic [3:0] {
    PH_HEADL  = 4'd0,
    PH_HEADF  = 4'd1,
    PH_BSYNC1 = 4'd2,
    PH_BSYNC2 = 4'd3,
    PH_SYN1   = 4'd4,
    PH_SYN2   = 4'd5,
    PH_SOH    = 4'd6,
    PH_TXT    = 4'd7,
    PH_CRC1   = 4'd8,
    PH_CRC2   = 4'd9,
    PH_END    = 4'd10
  } phase_t;

  // one result beat
  typedef struct packed {
    logic [3:0] next_bits;
    logic       char_valid;
    logic [7:0] char_out;
    logic [7:0] char_index;
    logic       frame_done;
    logic       crc_ok;
    logic [7:0] parity_errors;
    logic [7:0] parity_error_pos;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/acars_crc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acars_crc (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data_in,
  output logic      [15:0] crc_out
);
  import acars_pkg::*;

  // eight shifts, data fed lsb first into the low end
  always_comb begin
    logic [15:0] c;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      c = {c[14:0], data_in[i]} ^ (c[15] ? CRC_POLY : 16'h0000);
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// ===== rtl/acars_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acars_fsm (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_wdata,
  input  wire logic            step_en,
  input  wire logic [7:0]      byte_in,
  output acars_pkg::res_t      res
);
  import acars_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  bpc_r, bpc_nxt;
  logic [7:0]  bpp_r, bpp_nxt;
  logic [2:0]  mse_r;

  logic [15:0] crc_fed;
  logic [2:0]  ones_n;
  logic [7:0]  sync_err;
  logic [8:0]  pos_inc;
  logic [6:0]  chr;
  logic        par_bad;

  acars_crc u_crc (
    .crc_in  (crc_r),
    .data_in (byte_in),
    .crc_out (crc_fed)
  );

  // trailing ones of the first non-preamble byte, capped at seven
  always_comb begin
    ones_n = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (!byte_in[i]) ones_n = 3'(i);
    end
  end

  assign chr     = byte_in[6:0];
  assign par_bad = ~(^byte_in);
  assign pos_inc = {1'b0, pos_r} + 9'd1;

  // sync mismatch count including this byte
  always_comb begin
    logic miss;
    case (phase_r)
      PH_BSYNC1: miss = (byte_in != BYTE_BS1);
      PH_BSYNC2: miss = (byte_in != BYTE_BS2);
      PH_SYN1:   miss = (byte_in != BYTE_SYN);
      PH_SYN2:   miss = (byte_in != BYTE_SYN);
      PH_SOH:    miss = (byte_in != BYTE_SOH);
      default:   miss = 1'b0;
    endcase
    sync_err = pos_r + {7'd0, miss};
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADL;
      pos_r   <= '0;
      crc_r   <= '0;
      bpc_r   <= '0;
      bpp_r   <= '0;
      mse_r   <= MSE_RESET;
    end else begin
      if (cfg_we) mse_r <= cfg_wdata;
      if (step_en) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        crc_r   <= crc_nxt;
        bpc_r   <= bpc_nxt;
        bpp_r   <= bpp_nxt;
      end
    end
  end

  // next state and result for one byte
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    bpc_nxt   = bpc_r;
    bpp_nxt   = bpp_r;
    res       = '0;
    res.next_bits = NB_BYTE;

    case (phase_r)
      PH_HEADL: begin
        if (byte_in == BYTE_PRE) phase_nxt = PH_HEADF;
      end
      PH_HEADF: begin
        if (byte_in == BYTE_PRE) begin
          res.next_bits = NB_PRE;
        end else if (ones_n < 3'd2) begin
          phase_nxt = PH_HEADL;
        end else begin
          phase_nxt = PH_BSYNC1;
          pos_nxt   = '0;
          if (ones_n != 3'd2) res.next_bits = {1'b0, ones_n - 3'd2};
        end
      end
      PH_BSYNC1: begin
        pos_nxt   = sync_err;
        phase_nxt = PH_BSYNC2;
      end
      PH_BSYNC2: begin
        pos_nxt   = sync_err;
        phase_nxt = PH_SYN1;
      end
      PH_SYN1: begin
        pos_nxt   = sync_err;
        phase_nxt = PH_SYN2;
      end
      PH_SYN2: begin
        pos_nxt   = sync_err;
        phase_nxt = PH_SOH;
      end
      PH_SOH: begin
        if (sync_err > {5'd0, mse_r}) begin
          pos_nxt   = sync_err;
          phase_nxt = PH_HEADL;
        end else begin
          phase_nxt = PH_TXT;
          pos_nxt   = '0;
          crc_nxt   = '0;
          bpc_nxt   = '0;
          bpp_nxt   = '0;
        end
      end
      PH_TXT: begin
        crc_nxt = crc_fed;
        if (par_bad) begin
          if (bpc_r != 8'hFF) bpc_nxt = bpc_r + 8'd1;
          bpp_nxt = pos_r;
        end
        if (chr == CHR_ETX || chr == CHR_ETB) begin
          phase_nxt = PH_CRC1;
        end else begin
          res.char_valid = 1'b1;
          res.char_index = pos_r;
          if (chr < CHR_SPACE && !(chr inside {CHR_CR, CHR_LF, CHR_NAK})) begin
            res.char_out = CHR_SUBST;
          end else begin
            res.char_out = {1'b0, chr};
          end
          if (pos_inc > 9'(MAX_TEXT)) begin
            phase_nxt = PH_HEADL;
          end else begin
            pos_nxt = pos_inc[7:0];
          end
        end
      end
      PH_CRC1: begin
        crc_nxt   = crc_fed;
        phase_nxt = PH_CRC2;
      end
      PH_CRC2: begin
        crc_nxt   = crc_fed;
        phase_nxt = PH_END;
      end
      PH_END: begin
        phase_nxt            = PH_HEADL;
        res.frame_done       = 1'b1;
        res.crc_ok           = (crc_r == 16'h0000);
        if (crc_r == 16'h0000) res.next_bits = NB_DONE;
        res.parity_errors    = bpc_r;
        res.parity_error_pos = bpp_r;
      end
      default: begin
        phase_nxt = PH_HEADL;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/acars_frame_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// path: input register, frame state update, result register holding the beat
// throughput: one byte per cycle while out_ready does not stall the result
// input register and result register let a byte enter while a result waits
// reset (rst_n low, synchronous): both stages empty, preamble search,
// counters and crc cleared, max_sync_errors back to 2

module acars_frame_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      out_next_bits,
  output logic            out_char_valid,
  output logic [7:0]      out_char_out,
  output logic [7:0]      out_char_index,
  output logic            out_frame_done,
  output logic            out_crc_ok,
  output logic [7:0]      out_parity_errors,
  output logic [7:0]      out_parity_error_pos
);
  import acars_pkg::*;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       out_v_r;
  res_t       res_r;
  res_t       res_c;
  logic       adv;

  // the held byte moves on when the result register is free or draining
  assign adv      = ~out_v_r | out_ready;
  assign in_ready = ~in_v_r | adv;

  acars_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step_en   (in_v_r & adv),
    .byte_in   (in_byte_r),
    .res       (res_c)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_byte_r <= in_byte_in;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_v_r) res_r <= res_c;
  end

  assign out_valid            = out_v_r;
  assign out_next_bits        = res_r.next_bits;
  assign out_char_valid       = res_r.char_valid;
  assign out_char_out         = res_r.char_out;
  assign out_char_index       = res_r.char_index;
  assign out_frame_done       = res_r.frame_done;
  assign out_crc_ok           = res_r.crc_ok;
  assign out_parity_errors    = res_r.parity_errors;
  assign out_parity_error_pos = res_r.parity_error_pos;

endmodule

`default_nettype wire

// ===== verif/tb_acars_frame_decoder.sv =====
`timescale 1ns / 1ps

module tb_acars_frame_decoder;
  import acars_pkg::*;

  localparam int unsigned RAND_ITEMS = 1300;
  localparam int unsigned CFG_PHASES = 8;

  typedef enum logic [1:0] {
    ROW_DATA,
    ROW_CRC_HI,
    ROW_CRC_LO
  } row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [7:0] data;
    bit         fixed;
    res_t       want;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte_in;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] out_next_bits;
  logic       out_char_valid;
  logic [7:0] out_char_out;
  logic [7:0] out_char_index;
  logic       out_frame_done;
  logic       out_crc_ok;
  logic [7:0] out_parity_errors;
  logic [7:0] out_parity_error_pos;

  // decoder state as the testbench tracks it
  phase_t      dec_phase;
  logic [7:0]  dec_count;
  logic [15:0] dec_crc;
  logic [7:0]  dec_bad_cnt;
  logic [7:0]  dec_bad_pos;
  logic [2:0]  dec_max_err;

  res_t        decoded_q [$];
  dir_row_t    dir_rows [$];
  res_t        head;
  int unsigned mismatches;
  int unsigned bytes_sent;
  bit          in_steady;

  acars_frame_decoder uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_byte_in           (in_byte_in),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_next_bits        (out_next_bits),
    .out_char_valid       (out_char_valid),
    .out_char_out         (out_char_out),
    .out_char_index       (out_char_index),
    .out_frame_done       (out_frame_done),
    .out_crc_ok           (out_crc_ok),
    .out_parity_errors    (out_parity_errors),
    .out_parity_error_pos (out_parity_error_pos)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // crc-16 ccitt, zero start, byte fed lsb first into the low end
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        top;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      top = r[15];
      r = {r[14:0], b[i]};
      if (top)
        r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  // the two bytes that bring a running crc to zero
  function automatic logic [15:0] crc_tail(input logic [15:0] crc);
    logic [15:0] rem;
    logic [15:0] t;
    rem = crc16_feed(crc16_feed(crc, 8'h00), 8'h00);
    for (int i = 0; i < 8; i++) begin
      t[8 + i] = rem[15 - i];
      t[i]     = rem[7 - i];
    end
    return t;
  endfunction

  function automatic res_t quiet_beat(input logic [3:0] nb);
    res_t o;
    o = '0;
    o.next_bits = nb;
    return o;
  endfunction

  // advance the tracked decoder by one byte and return its result beat
  function automatic res_t decode_byte(input logic [7:0] r);
    res_t        o;
    int unsigned n;
    logic [7:0]  c;
    logic [8:0]  nxt;
    o = '0;
    o.next_bits = NB_BYTE;
    case (dec_phase)
      PH_HEADL: begin
        if (r == BYTE_PRE)
          dec_phase = PH_HEADF;
      end
      PH_HEADF: begin
        if (r == BYTE_PRE) begin
          o.next_bits = NB_PRE;
        end else begin
          n = 0;
          while (n < 7 && r[n])
            n++;
          if (n < 2) begin
            dec_phase = PH_HEADL;
          end else begin
            dec_phase = PH_BSYNC1;
            dec_count = '0;
            if (n != 2)
              o.next_bits = 4'(n - 2);
          end
        end
      end
      PH_BSYNC1: begin
        if (r != BYTE_BS1)
          dec_count++;
        dec_phase = PH_BSYNC2;
      end
      PH_BSYNC2: begin
        if (r != BYTE_BS2)
          dec_count++;
        dec_phase = PH_SYN1;
      end
      PH_SYN1: begin
        if (r != BYTE_SYN)
          dec_count++;
        dec_phase = PH_SYN2;
      end
      PH_SYN2: begin
        if (r != BYTE_SYN)
          dec_count++;
        dec_phase = PH_SOH;
      end
      PH_SOH: begin
        if (r != BYTE_SOH)
          dec_count++;
        if (dec_count > dec_max_err) begin
          dec_phase = PH_HEADL;
        end else begin
          dec_phase   = PH_TXT;
          dec_count   = '0;
          dec_crc     = '0;
          dec_bad_cnt = '0;
          dec_bad_pos = '0;
        end
      end
      PH_TXT: begin
        dec_crc = crc16_feed(dec_crc, r);
        // even number of ones is a parity failure
        if (~^r) begin
          if (dec_bad_cnt != 8'hFF)
            dec_bad_cnt++;
          dec_bad_pos = dec_count;
        end
        if (r[6:0] == CHR_ETX || r[6:0] == CHR_ETB) begin
          dec_phase = PH_CRC1;
        end else begin
          c = {1'b0, r[6:0]};
          if (r[6:0] < CHR_SPACE && r[6:0] != CHR_CR && r[6:0] != CHR_LF &&
              r[6:0] != CHR_NAK)
            c = CHR_SUBST;
          o.char_valid = 1'b1;
          o.char_out   = c;
          o.char_index = dec_count;
          nxt = {1'b0, dec_count} + 9'd1;
          if (nxt > MAX_TEXT)
            dec_phase = PH_HEADL;
          else
            dec_count = nxt[7:0];
        end
      end
      PH_CRC1: begin
        dec_crc = crc16_feed(dec_crc, r);
        dec_phase = PH_CRC2;
      end
      PH_CRC2: begin
        dec_crc = crc16_feed(dec_crc, r);
        dec_phase = PH_END;
      end
      PH_END: begin
        dec_phase = PH_HEADL;
        o.frame_done = 1'b1;
        o.crc_ok = (dec_crc == 16'h0000);
        if (o.crc_ok)
          o.next_bits = NB_DONE;
        o.parity_errors    = dec_bad_cnt;
        o.parity_error_pos = dec_bad_pos;
      end
      default: begin
        dec_phase = PH_HEADL;
      end
    endcase
    return o;
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic [7:0] data,
                                  input bit fixed, input res_t want);
    dir_row_t row;
    row.kind  = kind;
    row.data  = data;
    row.fixed = fixed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // odd parity in bit 7, now and then a random parity bit
  function automatic logic [7:0] with_parity(input logic [6:0] ch);
    logic p;
    p = ($urandom_range(0, 7) == 0) ? 1'($urandom) : ~^ch;
    return {p, ch};
  endfunction

  function automatic logic [7:0] text_char();
    logic [6:0] ch;
    do begin
      ch = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 31))
                                      : 7'($urandom_range(0, 127));
    end while (ch == CHR_ETX || ch == CHR_ETB);
    return with_parity(ch);
  endfunction

  function automatic logic [7:0] sync_or_junk(input logic [7:0] good);
    return ($urandom_range(0, 5) == 0) ? 8'($urandom) : good;
  endfunction

  // one input beat: optional gap, then hold valid until accepted
  task automatic send_byte(input logic [7:0] b, input bit fixed, input res_t want);
    res_t        got;
    int unsigned gap;
    gap = in_steady ? 0 : $urandom_range(0, 11);
    got = decode_byte(b);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    decoded_q.push_back(fixed ? want : got);
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // preamble, alignment, sync, text, terminator, crc and closing byte
  task automatic send_frame();
    logic [7:0]  fr [$];
    logic [7:0]  c;
    logic [6:0]  term;
    logic [15:0] crc;
    logic [15:0] tail;
    int unsigned n;
    int unsigned len;
    int unsigned cut;
    repeat ($urandom_range(1, 4)) fr.push_back(BYTE_PRE);
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 7);
    c = 8'($urandom);
    for (int i = 0; i < n; i++)
      c[i] = 1'b1;
    if (n < 7)
      c[n] = 1'b0;
    fr.push_back(c);
    fr.push_back(sync_or_junk(BYTE_BS1));
    fr.push_back(sync_or_junk(BYTE_BS2));
    fr.push_back(sync_or_junk(BYTE_SYN));
    fr.push_back(sync_or_junk(BYTE_SYN));
    fr.push_back(sync_or_junk(BYTE_SOH));
    // mostly short text, now and then near or past the length limit
    len = ($urandom_range(0, 14) == 0) ? $urandom_range(236, 250) : $urandom_range(0, 24);
    crc = '0;
    repeat (len) begin
      c = text_char();
      crc = crc16_feed(crc, c);
      fr.push_back(c);
    end
    term = $urandom_range(0, 1) ? CHR_ETX : CHR_ETB;
    c = with_parity(term);
    crc = crc16_feed(crc, c);
    fr.push_back(c);
    tail = crc_tail(crc);
    if ($urandom_range(0, 4) == 0)
      tail = tail ^ 16'($urandom_range(1, 65535));
    fr.push_back(tail[15:8]);
    fr.push_back(tail[7:0]);
    fr.push_back(8'($urandom));
    // some frames are cut short
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, fr.size() - 1) : fr.size();
    for (int i = 0; i < cut; i++)
      send_byte(fr[i], 1'b0, '0);
  endtask

  // drain, let the pipeline settle, then write the register
  task automatic write_max_errors(input logic [2:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    dec_max_err = v;
  endtask

  // result side: random stalls with stretches of none
  initial begin : result_sink
    int unsigned stall;
    int unsigned beats_left;
    bit          steady;
    out_ready  = 1'b0;
    beats_left = 0;
    steady     = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (beats_left == 0) begin
        steady     = ($urandom_range(0, 2) == 0);
        beats_left = $urandom_range(10, 60);
      end
      beats_left--;
      stall = steady ? 0 : $urandom_range(0, 11);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("result beat with nothing expected", out_next_bits, 0);
      end else begin
        head = decoded_q.pop_front();
        if (out_next_bits !== head.next_bits)
          report_mismatch("next_bits", out_next_bits, head.next_bits);
        if (out_char_valid !== head.char_valid)
          report_mismatch("char_valid", out_char_valid, head.char_valid);
        if (out_char_out !== head.char_out)
          report_mismatch("char_out", out_char_out, head.char_out);
        if (out_char_index !== head.char_index)
          report_mismatch("char_index", out_char_index, head.char_index);
        if (out_frame_done !== head.frame_done)
          report_mismatch("frame_done", out_frame_done, head.frame_done);
        if (out_crc_ok !== head.crc_ok)
          report_mismatch("crc_ok", out_crc_ok, head.crc_ok);
        if (out_parity_errors !== head.parity_errors)
          report_mismatch("parity_errors", out_parity_errors, head.parity_errors);
        if (out_parity_error_pos !== head.parity_error_pos)
          report_mismatch("parity_error_pos", out_parity_error_pos, head.parity_error_pos);
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [15:0] tail;
    logic [7:0]  b;
    int unsigned waited;
    int unsigned base;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_byte_in = '0;
    mismatches = 0;
    bytes_sent = 0;
    in_steady  = 1'b0;
    tail       = '0;
    dec_phase   = PH_HEADL;
    dec_count   = '0;
    dec_crc     = '0;
    dec_bad_cnt = '0;
    dec_bad_pos = '0;
    dec_max_err = MSE_RESET;

    // no preamble yet, preamble, weak alignment
    add_row(ROW_DATA, 8'h00, 1'b1, quiet_beat(NB_BYTE));
    add_row(ROW_DATA, BYTE_PRE, 1'b1, quiet_beat(NB_BYTE));
    add_row(ROW_DATA, BYTE_PRE, 1'b1, quiet_beat(NB_PRE));
    add_row(ROW_DATA, 8'hFE, 1'b1, quiet_beat(NB_BYTE));
    // seven trailing ones, then three bad sync bytes drop the frame
    add_row(ROW_DATA, BYTE_PRE, 1'b1, quiet_beat(NB_BYTE));
    add_row(ROW_DATA, 8'h7F, 1'b1, quiet_beat(4'd5));
    add_row(ROW_DATA, 8'h00, 1'b1, quiet_beat(NB_BYTE));
    add_row(ROW_DATA, 8'h00, 1'b1, quiet_beat(NB_BYTE));
    add_row(ROW_DATA, 8'h00, 1'b1, quiet_beat(NB_BYTE));
    add_row(ROW_DATA, BYTE_SYN, 1'b1, quiet_beat(NB_BYTE));
    add_row(ROW_DATA, BYTE_SOH, 1'b1, quiet_beat(NB_BYTE));
    // exactly two trailing ones and a clean header
    add_row(ROW_DATA, BYTE_PRE, 1'b1, quiet_beat(NB_BYTE));
    add_row(ROW_DATA, 8'h03, 1'b1, quiet_beat(NB_BYTE));
    add_row(ROW_DATA, BYTE_BS1, 1'b1, quiet_beat(NB_BYTE));
    add_row(ROW_DATA, BYTE_BS2, 1'b1, quiet_beat(NB_BYTE));
    add_row(ROW_DATA, BYTE_SYN, 1'b1, quiet_beat(NB_BYTE));
    add_row(ROW_DATA, BYTE_SYN, 1'b1, quiet_beat(NB_BYTE));
    add_row(ROW_DATA, BYTE_SOH, 1'b1, quiet_beat(NB_BYTE));
    // text: nul, cr, all ones, bad parity, nak with bad parity, then etb
    add_row(ROW_DATA, 8'h80, 1'b0, '0);
    add_row(ROW_DATA, 8'h0D, 1'b0, '0);
    add_row(ROW_DATA, 8'h7F, 1'b0, '0);
    add_row(ROW_DATA, 8'h00, 1'b0, '0);
    add_row(ROW_DATA, 8'h95, 1'b0, '0);
    add_row(ROW_DATA, 8'h97, 1'b0, '0);
    // good crc and the closing byte
    add_row(ROW_CRC_HI, 8'h00, 1'b0, '0);
    add_row(ROW_CRC_LO, 8'h00, 1'b0, '0);
    add_row(ROW_DATA, BYTE_PRE, 1'b0, '0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CRC_HI: begin
          tail = crc_tail(dec_crc);
          b = tail[15:8];
        end
        ROW_CRC_LO: b = tail[7:0];
        default:    b = dir_rows[i].data;
      endcase
      send_byte(b, dir_rows[i].fixed, dir_rows[i].want);
    end

    // random frames and noise under several register settings
    base = bytes_sent;
    for (int k = 0; k < CFG_PHASES; k++) begin
      write_max_errors((k == 0) ? 3'd0 : (k == 1) ? 3'd7 : 3'($urandom));
      while (bytes_sent < base + (k + 1) * RAND_ITEMS / CFG_PHASES) begin
        in_steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'b0, '0);
        end else begin
          send_frame();
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (decoded_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (decoded_q.size() != 0)
      report_mismatch("result beats never seen", decoded_q.size(), 0);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/acars_pkg.sv
rtl/acars_crc.sv
rtl/acars_fsm.sv
rtl/acars_frame_decoder.sv
verif/tb_acars_frame_decoder.sv
